// ===== design/lcs_pkg.sv =====
// lcs_pkg: shared types and constants of the streaming 3x3 LBP coder.
// No dependencies; imported by every module of the block.
`default_nettype none

package lcs_pkg;

	localparam int PIXEL_W      = 8;
	localparam int CODE_W       = 8;
	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_W        = 13;
	localparam int CFG_IDX_W    = 1;
	localparam int MIN_DIM      = 3;

	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// one classified pixel, front to back
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [COL_W-1:0]   col;
		logic               emit;
		logic               last;
	} lcs_item_t;

endpackage

`default_nettype wire

// ===== design/lbp_code_stream_core.sv =====
// lbp_code_stream_core: streaming 3x3 local binary pattern coder, top level.
// Depends on lcs_pkg, lcs_front, lcs_fifo and lcs_back.
//
// Usage:
//   Input channel (in_valid/in_stall/pixel) takes one grey pixel per transaction,
//   raster order. Output channel (out_valid/out_stall/code/last) gives one LBP code
//   per interior centre: pixel (r,c) with r,c >= 2 yields the code of centre
//   (r-1,c-1). Border pixels give no transaction; the consumer adds the border.
//   last marks the code caused by the frame's final pixel.
//   Config: cfg_write with cfg_index 0 = frame_width, 1 = frame_height, data on
//   cfg_data. Values saturate into [3,2048] and [3,4096]. Write only while idle.
// Throughput: one pixel per clock while out_stall is low, set by the single-port-read/
//   single-write line store pass in the back end (one read and one write per cycle).
// Path: a pixel's transaction writes the queue, then the line store read stage
//   loads, then the output register loads and out_valid rises; out_stall can hold
//   an emitting item in the read stage and so hold the queue behind it.
// Reset: counters, valid flags and geometry (640x480) clear at once; the line
//   store is not cleared and needs no clearing pass, since the first two rows
//   of a frame write every column before a read value enters a code.
// Stall: out_stall holds the output register; the back end then stops, the
//   4-entry queue fills and in_stall rises once it is full.
`default_nettype none

module lbp_code_stream_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [lcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lcs_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [lcs_pkg::PIXEL_W-1:0]   pixel,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [lcs_pkg::CODE_W-1:0]         code,
	output logic                               last
);
	import lcs_pkg::*;

	lcs_item_t front_item;
	lcs_item_t queue_item;
	logic      accept;
	logic      queue_full;
	logic      queue_valid;
	logic      queue_pop;

	// stall depends only on queue state, never on in_valid
	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	lcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pixel     (pixel),
		.item      (front_item)
	);

	lcs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_valid),
		.pop_item  (queue_item)
	);

	lcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (queue_valid),
		.q_item    (queue_item),
		.q_pop     (queue_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.code      (code),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== design/lcs_front.sv =====
// lcs_front: frame geometry registers, column/row counters and item classification.
// Depends on lcs_pkg.
`default_nettype none

module lcs_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [lcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lcs_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          accept,
	input  wire logic [lcs_pkg::PIXEL_W-1:0]   pixel,
	output lcs_pkg::lcs_item_t                 item
);
	import lcs_pkg::*;

	logic [COL_W-1:0]        width_m1_q;
	logic [ROW_W-1:0]        height_m1_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [WIDTH_REG_W-1:0]  w_raw;
	logic [HEIGHT_REG_W-1:0] h_raw;
	logic [COL_W-1:0]        w_m1;
	logic [ROW_W-1:0]        h_m1;
	logic                    row_end;
	logic                    frame_end;

	// saturate the written geometry, keep it as last index
	always_comb begin
		w_raw = cfg_data[WIDTH_REG_W-1:0];
		h_raw = cfg_data[HEIGHT_REG_W-1:0];
		priority if (w_raw < WIDTH_REG_W'(MIN_DIM)) begin
			w_m1 = COL_W'(MIN_DIM - 1);
		end else if (w_raw > WIDTH_REG_W'(MAX_WIDTH)) begin
			w_m1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			w_m1 = COL_W'(w_raw - WIDTH_REG_W'(1));
		end
		priority if (h_raw < HEIGHT_REG_W'(MIN_DIM)) begin
			h_m1 = ROW_W'(MIN_DIM - 1);
		end else if (h_raw > HEIGHT_REG_W'(MAX_HEIGHT)) begin
			h_m1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			h_m1 = ROW_W'(h_raw - HEIGHT_REG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_m1_q  <= COL_W'(WIDTH_RESET - 1);
			height_m1_q <= ROW_W'(HEIGHT_RESET - 1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_m1_q  <= w_m1;
				REG_FRAME_HEIGHT: height_m1_q <= h_m1;
				default:          ;
			endcase
		end
	end

	assign row_end   = (col_q >= width_m1_q);
	assign frame_end = row_end && (row_q >= height_m1_q);

	always_comb begin
		item.pixel = pixel;
		item.col   = col_q;
		item.emit  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
		item.last  = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/lcs_fifo.sv =====
// lcs_fifo: short register queue between front and back.
// Depends on lcs_pkg.
`default_nettype none

module lcs_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire lcs_pkg::lcs_item_t push_item,
	output logic                    full,
	input  wire logic               pop,
	output logic                    not_empty,
	output lcs_pkg::lcs_item_t      pop_item
);
	import lcs_pkg::*;

	lcs_item_t               slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_PTR_W:0]     count_q;

	assign full      = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (FIFO_PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (FIFO_PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/lcs_back.sv =====
// lcs_back: line store memory, 3x3 window, code compare and output register.
// Depends on lcs_pkg.
`default_nettype none

module lcs_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire lcs_pkg::lcs_item_t          q_item,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [lcs_pkg::CODE_W-1:0]       code,
	output logic                             last
);
	import lcs_pkg::*;

	// each entry holds {row r-2, row r-1} for one column
	logic [2*PIXEL_W-1:0] line_mem_q [MAX_WIDTH];

	lcs_item_t            item_s1;
	logic [2*PIXEL_W-1:0] rd_s1;
	logic                 valid_s1;
	logic                 adv_s1;

	// window columns c-2 (a) and c-1 (b) per row
	logic [PIXEL_W-1:0] top_a_q, top_b_q, mid_a_q, mid_b_q, bot_a_q, bot_b_q;
	logic [PIXEL_W-1:0] up, lo, ce;
	logic [CODE_W-1:0]  code_nx;
	logic [CODE_W-1:0]  code_q;
	logic               last_q;
	logic               out_valid_q;
	logic               out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!item_s1.emit || out_free);
	assign q_pop    = q_valid && (!valid_s1 || adv_s1);

	assign up = rd_s1[2*PIXEL_W-1:PIXEL_W];
	assign lo = rd_s1[PIXEL_W-1:0];
	assign ce = mid_b_q;

	always_comb begin
		code_nx[0] = top_a_q      >= ce;
		code_nx[1] = top_b_q      >= ce;
		code_nx[2] = up           >= ce;
		code_nx[3] = lo           >= ce;
		code_nx[4] = item_s1.pixel >= ce;
		code_nx[5] = bot_b_q      >= ce;
		code_nx[6] = bot_a_q      >= ce;
		code_nx[7] = mid_a_q      >= ce;
	end

	// read on pop, write back the shifted pair when the item leaves stage 1
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
			rd_s1   <= line_mem_q[q_item.col];
		end
		if (adv_s1) begin
			line_mem_q[item_s1.col] <= {lo, item_s1.pixel};
			top_a_q <= top_b_q;
			top_b_q <= up;
			mid_a_q <= mid_b_q;
			mid_b_q <= lo;
			bot_a_q <= bot_b_q;
			bot_b_q <= item_s1.pixel;
		end
		if (adv_s1 && item_s1.emit) begin
			code_q <= code_nx;
			last_q <= item_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1 && item_s1.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign code      = code_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== design/lcs_checker.sv =====
// lcs_checker: port-level assertions for lbp_code_stream_core, bound to the top level.
// Depends on lcs_pkg and lbp_code_stream_core.
`default_nettype none

module lcs_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [lcs_pkg::CODE_W-1:0]  code,
	input wire logic                        last
);
	import lcs_pkg::*;

	logic seen_in_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			seen_in_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(code) && $stable(last))
		else $error("output payload changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_in_q)
		else $error("result shown before any pixel transaction");

	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("queue filled without an input transaction");

endmodule

bind lbp_code_stream_core lcs_checker u_lcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.code      (code),
	.last      (last)
);

`default_nettype wire

// ===== sim/lbp_code_stream_core_tb.sv =====
// lbp_code_stream_core_tb: self-checking bench for the streaming 3x3 LBP coder.
// Depends on lcs_pkg and lbp_code_stream_core; keeps its own line stores, window
// and raster counters to predict every code and its last flag.
`default_nettype none

module lbp_code_stream_core_tb;
	import lcs_pkg::*;

	localparam int QUIET_LIMIT = 2000;	// cycles with no transaction on either side
	localparam int HOLD_CYCLES = 300;	// long receiver hold-off
	localparam int DRAIN_PAUSE = 8;		// lets border pixels drain through the queue and line store read stage

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} lbp_code_t;

	typedef enum int {PIX_ANY, PIX_CLOSE, PIX_RAIL} pix_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIXEL_W-1:0] pixel = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CODE_W-1:0] code;
	logic last;

	lbp_code_stream_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.code      (code),
		.last      (last)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow of the coder: geometry registers, line stores, window, counters
	// ---------------------------------------------------------------
	logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_REG_W'(WIDTH_RESET);
	logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_REG_W'(HEIGHT_RESET);
	logic [PIXEL_W-1:0] row_above [MAX_WIDTH];	// row r-2
	logic [PIXEL_W-1:0] row_prev  [MAX_WIDTH];	// row r-1
	logic [PIXEL_W-1:0] win [3][3];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;

	lbp_code_t   pending_codes[$];	// codes owed by the DUT, oldest first
	logic [PIXEL_W-1:0] pixel_backlog[$];	// pixels not yet taken by the DUT

	int unsigned mismatch_cnt = 0;
	int unsigned quiet_cycles = 0;
	logic pix_taken = 1'b0;

	// traffic shaping, set per phase by the stimulus process
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	initial begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			row_above[i] = '0;
			row_prev[i] = '0;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				win[r][c] = '0;
	end

	function automatic int unsigned frame_cols();
		int unsigned w;
		w = width_reg;
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned frame_rows();
		int unsigned h;
		h = height_reg;
		if (h < MIN_DIM) h = MIN_DIM;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		return h;
	endfunction

	// Valid only while idle: pixels still owed before the frame wraps.
	function automatic int unsigned pixels_to_frame_end();
		int unsigned w;
		int unsigned h;
		int unsigned rows_left;
		w = frame_cols();
		h = frame_rows();
		rows_left = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
		return rows_left * w + ((col_pos >= w - 1) ? 1 : w - col_pos);
	endfunction

	// Advance the shadow by one pixel; queue the code it produces, if any.
	task automatic lbp_predict(input logic [PIXEL_W-1:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned idx;
		logic [PIXEL_W-1:0] ce;
		bit row_end;
		bit frame_end;
		lbp_code_t res;
		w = frame_cols();
		h = frame_rows();
		idx = col_pos % MAX_WIDTH;
		row_end = (col_pos >= w - 1);
		frame_end = row_end && (row_pos >= h - 1);
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = row_above[idx];
		win[1][2] = row_prev[idx];
		win[2][2] = px;
		row_above[idx] = row_prev[idx];
		row_prev[idx] = px;
		if (row_pos >= 2 && col_pos >= 2) begin
			ce = win[1][1];
			// clockwise from top-left
			res.code[0] = (win[0][0] >= ce);
			res.code[1] = (win[0][1] >= ce);
			res.code[2] = (win[0][2] >= ce);
			res.code[3] = (win[1][2] >= ce);
			res.code[4] = (win[2][2] >= ce);
			res.code[5] = (win[2][1] >= ce);
			res.code[6] = (win[2][0] >= ce);
			res.code[7] = (win[1][0] >= ce);
			res.last = frame_end;
			pending_codes.push_back(res);
		end
		if (row_end) begin
			col_pos = 0;
			row_pos = frame_end ? 0 : ((row_pos + 1) & 32'hFFF);
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	task automatic log_mismatch(input string what);
		mismatch_cnt++;
		$display("lbp check @%0t: %s", $time, what);
	endtask

	// ---------------------------------------------------------------
	// Monitor: both channels and the config port, sampled at the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		lbp_code_t want;
		bit in_acc;
		bit out_acc;
		in_acc = in_valid && !in_stall;
		out_acc = out_valid && !out_stall;
		if (arst_n) begin
			if (cfg_write) begin
				if (cfg_index == REG_FRAME_WIDTH)
					width_reg = cfg_data[WIDTH_REG_W-1:0];
				else if (cfg_index == REG_FRAME_HEIGHT)
					height_reg = cfg_data[HEIGHT_REG_W-1:0];
			end
			if (in_acc) begin
				lbp_predict(pixel);
				void'(pixel_backlog.pop_front());
			end
			if (out_acc) begin
				if (pending_codes.size() == 0) begin
					log_mismatch($sformatf("code %02h last %0b with nothing expected",
						code, last));
				end else begin
					want = pending_codes.pop_front();
					if (code !== want.code)
						log_mismatch($sformatf("code %02h, expected %02h",
							code, want.code));
					if (last !== want.last)
						log_mismatch($sformatf("last %0b, expected %0b (code %02h)",
							last, want.last, want.code));
				end
			end
			quiet_cycles <= (in_acc || out_acc) ? 0 : quiet_cycles + 1;
		end
		pix_taken <= in_acc;
	end

	// ---------------------------------------------------------------
	// Driver: offers backlog pixels at the falling edge, holds while stalled
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !pix_taken)) begin
			if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				in_valid <= 1'b1;
				pixel <= pixel_backlog[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: ends the run when traffic stops for too long
	initial begin
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("lbp_code_stream_core_tb: done, errors");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic wait_idle();
		while (pixel_backlog.size() != 0 || pending_codes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic pix_style_t pick_style();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 50) return PIX_ANY;
		if (roll < 85) return PIX_CLOSE;
		return PIX_RAIL;
	endfunction

	task automatic push_pixels(input int unsigned n, input pix_style_t style);
		logic [PIXEL_W-1:0] px;
		for (int unsigned i = 0; i < n; i++) begin
			case (style)
				PIX_ANY:   px = PIXEL_W'($urandom_range(255));
				PIX_CLOSE: px = PIXEL_W'(126 + $urandom_range(2));	// many ties
				default:   px = $urandom_range(1) ? 8'hFF : 8'h00;
			endcase
			pixel_backlog.push_back(px);
		end
	endtask

	task automatic set_traffic(input int unsigned phase);
		case (phase % 4)
			0: begin send_gap_pct = 0;  stall_pct = 0;  end
			1: begin send_gap_pct = 52; stall_pct = 0;  end
			2: begin send_gap_pct = 0;  stall_pct = 52; end
			default: begin send_gap_pct = 8; stall_pct = 8; end
		endcase
	endtask

	// Whole frames of one geometry until the pixel budget is spent.
	task automatic run_geometry(input logic [CFG_W-1:0] wval, input logic [CFG_W-1:0] hval,
			input int unsigned budget, input int unsigned phase);
		int unsigned fsize;
		int unsigned sent;
		wait_idle();
		write_reg(REG_FRAME_WIDTH, wval);
		write_reg(REG_FRAME_HEIGHT, hval);
		set_traffic(phase);
		fsize = pixels_to_frame_end();
		sent = 0;
		do begin
			push_pixels(fsize, pick_style());
			sent += fsize;
		end while (sent < budget);
	endtask

	// Geometry change in the middle of a frame, then finish that frame.
	task automatic reshape_mid_frame(input logic [CFG_W-1:0] wval,
			input logic [CFG_W-1:0] hval, input int unsigned lead,
			input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
			input int unsigned phase);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, wval);
		write_reg(REG_FRAME_HEIGHT, hval);
		set_traffic(phase);
		push_pixels(lead, pick_style());
		wait_idle();
		write_reg(idx, val);
		push_pixels(pixels_to_frame_end(), pick_style());
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Reset geometry 640x480: one full row plus a few pixels, then narrow the
		// width inside row 1 and lower the height; row 2 becomes the last.
		push_pixels(WIDTH_RESET + 3, PIX_ANY);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 13'd4);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		push_pixels(pixels_to_frame_end(), PIX_CLOSE);

		// Directed 3x3 frames (width and height below range saturate to 3):
		// mixed bits with a tie, all ones, all zeros.
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 13'd0);
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		pixel_backlog = {pixel_backlog,
			8'h00, 8'hFF, 8'h00,  8'hFF, 8'h80, 8'h80,  8'h00, 8'h7F, 8'hFF,
			8'hFF, 8'hFF, 8'hFF,  8'hFF, 8'h00, 8'hFF,  8'hFF, 8'hFF, 8'hFF,
			8'hFE, 8'hFE, 8'hFE,  8'hFE, 8'hFF, 8'hFE,  8'hFE, 8'hFE, 8'hFE};

		// Random frames over a spread of geometries and traffic patterns.
		run_geometry(13'd3, 13'd3, 50, 0);
		run_geometry(13'h1004, 13'd5, 40, 1);	// bit 12 of width data ignored
		run_geometry(13'd1, 13'd0, 30, 2);
		run_geometry(13'd7, 13'd4, 50, 3);
		hold_asks++;	// receiver holds off while the sender keeps offering
		run_geometry(13'd16, 13'd6, 90, 0);
		run_geometry(13'd33, 13'd3, 90, 1);
		run_geometry(13'd5, 13'd8, 40, 2);
		run_geometry(13'd40, 13'd3, 1, 3);
		run_geometry(13'd11, 13'd7, 1, 2);

		// Extremes: over-range width and height saturate to 2048 and 4096;
		// run part of such a frame, then cut it short.
		reshape_mid_frame(13'd4095, 13'd3, 40, REG_FRAME_WIDTH, 13'd24, 0);
		reshape_mid_frame(13'd3, 13'd8191, 30, REG_FRAME_HEIGHT, 13'd3, 1);

		// Mid-frame changes: height down to the current row, height below it,
		// width narrowed inside a row.
		reshape_mid_frame(13'd8, 13'd50, 35, REG_FRAME_HEIGHT, 13'd5, 2);
		reshape_mid_frame(13'd5, 13'd40, 32, REG_FRAME_HEIGHT, 13'd3, 3);
		reshape_mid_frame(13'd10, 13'd6, 34, REG_FRAME_WIDTH, 13'd6, 1);

		run_geometry(13'd4, 13'd4, 1, 3);

		wait_idle();
		if (mismatch_cnt == 0)
			$display("lbp_code_stream_core_tb: done, clean");
		else
			$display("lbp_code_stream_core_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
